### design/tdpb_pkg.sv
// ----------------------------------------------------------------------------
// tdpb_pkg
// Shared types and field widths for the tail drop packet buffer.
// ----------------------------------------------------------------------------
package tdpb_pkg;

    localparam int TIME_W = 32;
    localparam int PROC_W = 16;
    localparam int SIZE_W = 7;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;
    localparam logic [TIME_W-1:0] TIME_MAX   = '1;

    typedef logic [TIME_W-1:0] time_val_t;
    typedef logic [PROC_W-1:0] proc_val_t;
    typedef logic [SIZE_W-1:0] size_val_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_CHECK
    } tdpb_state_t;

endpackage

### design/tdpb_if.sv
// ----------------------------------------------------------------------------
// tdpb_if
// Valid/ready channels: packet input and per-packet result output.
// ----------------------------------------------------------------------------
interface tdpb_pkt_if;
    logic                  valid;
    logic                  ready;
    tdpb_pkg::time_val_t   arr_stamp;
    tdpb_pkg::proc_val_t   proc_len;

    modport source (output valid, output arr_stamp, output proc_len, input ready);
    modport sink   (input valid, input arr_stamp, input proc_len, output ready);
endinterface

interface tdpb_res_if;
    logic                  valid;
    logic                  ready;
    logic                  dropped;
    tdpb_pkg::time_val_t   start_stamp;

    modport source (output valid, output dropped, output start_stamp, input ready);
    modport sink   (input valid, input dropped, input start_stamp, output ready);
endinterface

### design/tail_drop_packet_buffer_core.sv
// Sequence: after a packet is accepted, the finish times retired for it are popped
// (one head read per cycle); its result is then registered once res_out has room,
// i.e. the previous result has gone or is taken in that cycle.
// A new packet is not taken until the current packet's result has been decided.
// A finished result waits in the output register while the next packet is taken.
// Reset: head, count, handshake state cleared, buffer_size 64; ring not cleared.
// ----------------------------------------------------------------------------
// tail_drop_packet_buffer_core
// Single-server packet buffer with tail drop; finish times in a ring memory.
// ----------------------------------------------------------------------------
module tail_drop_packet_buffer_core #(
    parameter int DEPTH = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  tdpb_pkg::size_val_t       cfg_wdata,
    tdpb_pkt_if.sink                  pkt_in,
    tdpb_res_if.source                res_out
);
    import tdpb_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int CMP_W = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

    tdpb_state_t       state_reg, state_next;
    size_val_t         size_reg;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    time_val_t         last_finish_reg;
    time_val_t         arr_reg;
    proc_val_t         proc_reg;
    time_val_t         rd_data_reg;
    logic              out_valid_reg, out_valid_next;
    logic              out_dropped_reg;
    time_val_t         out_start_reg;

    time_val_t         ring_mem [DEPTH];

    logic              accept;
    logic              retire;
    logic              slot_free;
    logic              decide;
    logic              full;
    logic              append;
    logic [CNT_W-1:0]  limit;
    logic [CMP_W-1:0]  size_ext;
    logic [SUM_W-1:0]  tail_sum;
    logic [IDX_W-1:0]  tail_idx;
    time_val_t         start_val;
    logic [TIME_W:0]   finish_sum;
    time_val_t         finish_val;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (decide)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        pkt_in.ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:  pkt_in.ready = 1'b1;
            ST_CHECK: pkt_in.ready = 1'b0;
            default:  pkt_in.ready = 1'b0;
        endcase
    end

    assign accept    = pkt_in.valid && pkt_in.ready;
    assign slot_free = !out_valid_reg || res_out.ready;

    // rd_data_reg always holds ring_mem[head_reg] while checking
    assign retire = (state_reg == ST_CHECK) && (count_reg != '0) && (rd_data_reg <= arr_reg);
    assign decide = (state_reg == ST_CHECK) && !retire && slot_free;

    assign size_ext = CMP_W'(size_reg);
    assign limit    = (size_ext > CMP_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(size_ext);
    assign full     = (count_reg >= limit);
    assign append   = decide && !full;

    assign start_val  = (count_reg != '0) ? last_finish_reg : arr_reg;
    assign finish_sum = {1'b0, start_val} + (TIME_W + 1)'(proc_reg);
    assign finish_val = finish_sum[TIME_W] ? TIME_MAX : finish_sum[TIME_W-1:0];

    // head + count never reaches twice the depth
    assign tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail_idx = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                                  : IDX_W'(tail_sum);

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (retire)
        begin
            head_next  = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
        else if (append)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    assign out_valid_next = (out_valid_reg && !res_out.ready) || decide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            size_reg      <= SIZE_RESET;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                size_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            arr_reg  <= pkt_in.arr_stamp;
            proc_reg <= pkt_in.proc_len;
        end
        if (append)
            last_finish_reg <= finish_val;
        if (decide)
        begin
            out_dropped_reg <= full;
            out_start_reg   <= full ? '0 : start_val;
        end
    end

    // Ring memory: one write, one registered read at the next head
    always_ff @(posedge clk)
    begin
        if (append)
            ring_mem[tail_idx] <= finish_val;
        rd_data_reg <= ring_mem[head_next];
    end

    assign res_out.valid       = out_valid_reg;
    assign res_out.dropped     = out_dropped_reg;
    assign res_out.start_stamp = out_start_reg;

endmodule

### design/tdpb_checker.sv
// ----------------------------------------------------------------------------
// tdpb_checker
// Port-level checks for the tail drop packet buffer, bound to the top level.
// ----------------------------------------------------------------------------
module tdpb_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cfg_we,
    input tdpb_pkg::size_val_t  cfg_wdata,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic                 dropped,
    input tdpb_pkg::time_val_t  start_stamp
);
    import tdpb_pkg::*;

    logic size_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_zero_reg <= 1'b0;
        else if (cfg_we)
            size_zero_reg <= (cfg_wdata == '0);
    end

    // a dropped packet reports start 0
    a_drop_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && dropped) |-> (start_stamp == '0))
        else $error("dropped result with nonzero start");

    // one packet in flight: input closes right after a transaction
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted again before previous packet resolved");

    // zero-size buffer drops everything
    a_zero_size_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && size_zero_reg) |-> dropped)
        else $error("packet kept with buffer_size zero");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(dropped) && $stable(start_stamp)))
        else $error("stalled result changed");

endmodule

bind tail_drop_packet_buffer_core tdpb_checker u_tdpb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (pkt_in.valid),
    .in_ready    (pkt_in.ready),
    .out_valid   (res_out.valid),
    .out_ready   (res_out.ready),
    .dropped     (res_out.dropped),
    .start_stamp (res_out.start_stamp)
);

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for tail_drop_packet_buffer_core. The bench queues packet
// timelines under several buffer sizes, holds a scoreboard of start times and
// drop flags, and compares every result transaction in order.
// ----------------------------------------------------------------------------
module tb;
    import tdpb_pkg::*;

    localparam int RING_DEPTH  = 64;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int NUM_PHASES  = 12;

    typedef struct packed {
        time_val_t arrival;
        proc_val_t ptime;
    } pkt_item_t;

    typedef struct packed {
        logic      dropped;
        time_val_t start_stamp;
    } pkt_result_t;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    size_val_t cfg_wdata;

    tdpb_pkt_if pkt_if ();
    tdpb_res_if res_if ();

    tail_drop_packet_buffer_core #(
        .DEPTH(RING_DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .pkt_in   (pkt_if),
        .res_out  (res_if)
    );

    pkt_item_t   pend_pkts[$];
    pkt_result_t exp_results[$];
    time_val_t   sched_finish[$];  // finish times of packets still held
    size_val_t   buf_cap;
    time_val_t   arr_now;
    int          err_count;
    int          cycle_cnt;
    int          gap_left;
    int          stall_left;
    bit          pkt_fire;
    bit          snd_jitter;
    bit          rcv_jitter;

    int size_plan [NUM_PHASES] = '{64, 127, 2, 65, 1, 0, 100, 3, 64, 33, 127, 8};
    int gap_plan  [NUM_PHASES] = '{20, 2, 10, 3, 12, 5, 4, 8, 25, 3, 1, 6};
    int proc_plan [NUM_PHASES] = '{30, 60, 30, 40, 30, 20, 30, 40, 20, 50, 40, 30};

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic int pick_gap(input bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    task automatic log_error(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("ERROR: %s", msg);
    endtask

    // Retire, then tail drop or append; start follows the last held finish time.
    task automatic serve_packet(input time_val_t arr, input proc_val_t pt,
                                output pkt_result_t res);
        int          lim;
        time_val_t   st;
        logic [32:0] fin;
        lim = (buf_cap > RING_DEPTH) ? RING_DEPTH : int'(buf_cap);
        while (sched_finish.size() > 0 && sched_finish[0] <= arr)
            void'(sched_finish.pop_front());
        if (sched_finish.size() >= lim)
        begin
            res.dropped     = 1'b1;
            res.start_stamp = '0;
        end
        else
        begin
            st  = (sched_finish.size() > 0) ? sched_finish[$] : arr;
            fin = {1'b0, st} + {17'd0, pt};
            sched_finish = {sched_finish, (fin[32] ? TIME_MAX : fin[31:0])};
            res.dropped     = 1'b0;
            res.start_stamp = st;
        end
    endtask

    // Monitor and scoreboard
    always @(posedge clk)
    begin
        pkt_result_t got;
        pkt_result_t want;
        if (!rst_n)
        begin
            pkt_fire <= 1'b0;
            buf_cap = SIZE_RESET;
            sched_finish.delete();
        end
        else
        begin
            if (cfg_we)
                buf_cap = cfg_wdata;
            if (res_if.valid && res_if.ready)
            begin
                got.dropped     = res_if.dropped;
                got.start_stamp = res_if.start_stamp;
                if (exp_results.size() == 0)
                    log_error($sformatf("unexpected result: dropped=%0b start=%0h",
                                        got.dropped, got.start_stamp));
                else
                begin
                    want = exp_results.pop_front();
                    if (got.dropped !== want.dropped || got.start_stamp !== want.start_stamp)
                        log_error($sformatf(
                            "expected dropped=%0b start=%0h, got dropped=%0b start=%0h",
                            want.dropped, want.start_stamp, got.dropped, got.start_stamp));
                end
            end
            // result checked first so a same-edge packet can't mask an extra result
            pkt_fire <= pkt_if.valid && pkt_if.ready;
            if (pkt_if.valid && pkt_if.ready)
            begin
                serve_packet(pkt_if.arr_stamp, pkt_if.proc_len, want);
                exp_results = {exp_results, want};
            end
        end
    end

    // Packet driver
    always @(negedge clk)
    begin
        pkt_item_t it;
        if (rst_n && (pkt_fire || !pkt_if.valid))
        begin
            if (pkt_fire)
                gap_left = pick_gap(snd_jitter);
            if (gap_left > 0 || pend_pkts.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                pkt_if.valid <= 1'b0;
            end
            else
            begin
                it = pend_pkts.pop_front();
                pkt_if.valid     <= 1'b1;
                pkt_if.arr_stamp <= it.arrival;
                pkt_if.proc_len  <= it.ptime;
            end
        end
    end

    // Result backpressure
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            res_if.ready <= 1'b0;
        end
        else
        begin
            res_if.ready <= 1'b1;
            stall_left = pick_gap(rcv_jitter);
        end
    end

    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic push_pkt(input time_val_t a, input proc_val_t p);
        pkt_item_t it;
        it.arrival = a;
        it.ptime   = p;
        pend_pkts  = {pend_pkts, it};
    endtask

    task automatic write_size(input size_val_t v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Sender holds off until every outstanding result has come back.
    task automatic wait_idle();
        while (pend_pkts.size() != 0 || pkt_if.valid || exp_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Mostly nondecreasing arrivals with occasional steps back and long jumps.
    task automatic queue_traffic(input int n, input int mean_gap, input int max_proc);
        int        k;
        int        r;
        proc_val_t p;
        for (k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                arr_now = arr_now - $urandom_range(1, 500);
            else if (r < 5)
                arr_now = arr_now + $urandom_range(1000, 1 << 20);
            else
                arr_now = arr_now + $urandom_range(0, 2 * mean_gap);
            if ($urandom_range(0, 99) < 2)
                p = proc_val_t'($urandom);
            else
                p = proc_val_t'($urandom_range(0, max_proc));
            push_pkt(arr_now, p);
        end
    endtask

    initial
    begin
        int ph;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        pkt_if.valid     = 1'b0;
        pkt_if.arr_stamp = '0;
        pkt_if.proc_len  = '0;
        res_if.ready     = 1'b0;
        err_count        = 0;
        gap_left         = 0;
        stall_left       = 0;
        snd_jitter       = 1'b1;
        rcv_jitter       = 1'b1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset size: zero-length jobs, longest job, saturation, backward arrival
        push_pkt(32'd0, 16'd0);
        push_pkt(32'd0, 16'hFFFF);
        push_pkt(32'd0, 16'd1);
        push_pkt(32'd65536, 16'd0);
        push_pkt(32'd1000, 16'd7);
        push_pkt(32'hFFFF_0000, 16'hFFFF);
        push_pkt(32'hFFFF_0001, 16'hFFFF);
        push_pkt(32'hFFFF_FFFE, 16'd10);
        push_pkt(32'hFFFF_FFFF, 16'd0);
        push_pkt(32'd0, 16'd3);
        wait_idle();

        // Size zero drops everything; the max arrival also flushes saturated entries
        write_size(size_val_t'(0));
        push_pkt(32'd5, 16'd5);
        push_pkt(32'hFFFF_FFFF, 16'hFFFF);
        wait_idle();

        write_size(size_val_t'(1));
        push_pkt(32'd100, 16'd50);
        push_pkt(32'd100, 16'd50);
        push_pkt(32'd149, 16'd1);
        push_pkt(32'd150, 16'd1);
        wait_idle();

        arr_now = 32'd1000;
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            snd_jitter = (ph % 4 == 0) || (ph % 4 == 1);
            rcv_jitter = (ph % 4 == 0) || (ph % 4 == 2);
            write_size(size_val_t'(size_plan[ph]));
            if (ph == 3 || ph == 8)
                arr_now = $urandom;
            else if (ph == 4)
                arr_now = 32'hFFFF_FF00;   // wraps around the top of the range
            else if (ph == 5)
            begin
                push_pkt(32'hFFFF_FFFF, proc_val_t'($urandom));
                arr_now = $urandom_range(0, 1 << 30);
            end
            queue_traffic($urandom_range(130, 160), gap_plan[ph], proc_plan[ph]);
            wait_idle();
        end

        repeat (20) @(posedge clk);
        if (exp_results.size() != 0)
            log_error($sformatf("%0d results never arrived", exp_results.size()));
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
design/tdpb_pkg.sv
design/tdpb_if.sv
design/tail_drop_packet_buffer_core.sv
design/tdpb_checker.sv
tb/tb.sv
